[design/fdc_pkg.sv]
// Package: types and constants for the floppy disk controller.
`timescale 1ns / 1ps
package fdc_pkg;
  localparam int unsigned ImageBytes  = 2097152;
  localparam int unsigned DriveCount  = 4;
  localparam int unsigned FifoDepth   = 16;
  localparam int unsigned SectorBytes = 512;
  localparam int unsigned OffW        = $clog2(ImageBytes);
  localparam int unsigned DrvW        = (DriveCount > 1) ? $clog2(DriveCount) : 1;
  localparam int unsigned AddrW       = 23;
  localparam logic [AddrW:0] StoreLimit = (AddrW+1)'(DriveCount * ImageBytes);

  localparam logic [7:0] StBusy = 8'b1000_0000;
  localparam logic [7:0] StDrq  = 8'b0010_0000;
  localparam logic [7:0] CmdRd  = 8'd1;
  localparam logic [7:0] CmdWr  = 8'd2;
  localparam logic [7:0] CmdSk  = 8'd4;

  typedef enum logic [2:0] {
    OP_BUS_READ = 3'd0, OP_BUS_WRITE = 3'd1, OP_TICK = 3'd2,
    OP_LOAD = 3'd3, OP_DUMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0, PH_ARGS = 2'd1, PH_EXEC = 2'd2, PH_RESULT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_HEADS = 3'd0, CFG_SECTORS = 3'd1, CFG_RD_PER = 3'd2,
    CFG_WR_PER = 3'd3, CFG_SEEK = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_EXEC, ST_OUT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  op;
    logic        port;
    logic [7:0]  value;
    logic [22:0] image_addr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } cfg_t;
endpackage

[design/floppy_disk_controller.sv]
// Top level: disk controller with phase machine, data FIFO and disk store.
`timescale 1ns / 1ps
// For each item, the disk store and data FIFO (both synchronous memories with
// registered reads) are read as the item is taken; then state is updated and
// written back. Starting a sector transfer (the fourth argument byte of a read
// or write command) also passes through ST_MUL1 and ST_MUL2 for the sector
// address multiplies. A result waits in an output register; the next item is
// taken once it has gone. The zero result byte that ends a sector enters the
// FIFO in the first cycle the result waits. No clearing pass: the stores are
// undefined until written.
module floppy_disk_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fdc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fdc_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  fdc_pkg::cfg_t        cfg_data_i
);
  localparam int unsigned OffW = fdc_pkg::OffW;
  localparam int unsigned DrvW = fdc_pkg::DrvW;

  // configuration
  logic [1:0] heads_q;
  logic [5:0] spt_q;
  logic [3:0] rd_per_q, wr_per_q;
  logic [7:0] seek_dly_q;

  // controller state
  fdc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [2:0]  args_taken_q, args_taken_d, args_needed_q, args_needed_d;
  logic [1:0]  drive_q, drive_d;
  logic [7:0]  head_q, head_d, track_q, track_d, sector_q, sector_d;
  logic [OffW-1:0] off_q, off_d;
  logic [3:0]  cnt_q, cnt_d, per_q, per_d;
  logic [12:0] ticks_q, ticks_d;
  logic [7:0]  seek_q, seek_d;
  logic [3:0]  head_ptr_q, head_ptr_d;
  logic [4:0]  fcount_q, fcount_d;
  logic [7:0]  status_q, status_d;
  logic        irq_q, irq_d;
  logic        zero_pend_q, zero_pend_d;
  logic [3:0]  zero_addr_q, zero_addr_d;

  fdc_pkg::fsm_e    fsm_q, fsm_d;
  fdc_pkg::in_item_t item_q;
  fdc_pkg::out_item_t out_q, out_d;

  // memories
  logic [7:0] disk_mem [2**fdc_pkg::AddrW];
  logic [7:0] fifo_mem [fdc_pkg::FifoDepth];
  logic [7:0] disk_rd_q, fifo_rd_q;
  logic [fdc_pkg::AddrW-1:0] disk_raddr;
  logic [3:0] fifo_raddr;
  logic        disk_we, fifo_we;
  logic [fdc_pkg::AddrW-1:0] disk_waddr;
  logic [7:0] disk_wdata, fifo_wdata;
  logic [3:0] fifo_waddr;

  // sector address pipeline; only the low bits of the linear sector matter
  logic [15:0] mul1_q;
  logic [11:0] lin;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o  = (fsm_q == fdc_pkg::ST_IDLE);
  assign out_valid_o = (fsm_q == fdc_pkg::ST_OUT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_q <= 2'd2; spt_q <= 6'd18; rd_per_q <= 4'd11; wr_per_q <= 4'd4;
      seek_dly_q <= 8'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_data_i.index)
        fdc_pkg::CFG_HEADS:   heads_q    <= cfg_data_i.data[1:0];
        fdc_pkg::CFG_SECTORS: spt_q      <= cfg_data_i.data[5:0];
        fdc_pkg::CFG_RD_PER:  rd_per_q   <= cfg_data_i.data[3:0];
        fdc_pkg::CFG_WR_PER:  wr_per_q   <= cfg_data_i.data[3:0];
        fdc_pkg::CFG_SEEK:    seek_dly_q <= cfg_data_i.data;
        default: ;
      endcase
    end
  end

  // read addresses: dump from the item, else drive/offset; FIFO at the head
  always_comb begin
    if (in_data_i.op == fdc_pkg::OP_DUMP) begin
      disk_raddr = in_data_i.image_addr;
    end else begin
      disk_raddr = {drive_q[DrvW-1:0], off_q};
    end
    fifo_raddr = head_ptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      disk_rd_q <= disk_mem[disk_raddr];
      fifo_rd_q <= fifo_mem[fifo_raddr];
      item_q    <= in_data_i;
    end
    if (disk_we) disk_mem[disk_waddr] <= disk_wdata;
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    if (fsm_q == fdc_pkg::ST_MUL1) mul1_q <= 16'(track_q * heads_q) + 16'(head_q);
    if (fsm_q == fdc_pkg::ST_EXEC) out_q <= out_d;
  end

  // sequencer: next state
  logic start_xfer;
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      fdc_pkg::ST_IDLE: if (in_fire) fsm_d = fdc_pkg::ST_EXEC;
      fdc_pkg::ST_EXEC: fsm_d = start_xfer ? fdc_pkg::ST_MUL1 : fdc_pkg::ST_OUT;
      fdc_pkg::ST_MUL1: fsm_d = fdc_pkg::ST_MUL2;
      fdc_pkg::ST_MUL2: fsm_d = fdc_pkg::ST_OUT;
      fdc_pkg::ST_OUT:  if (out_fire) fsm_d = fdc_pkg::ST_IDLE;
      default: fsm_d = fdc_pkg::ST_IDLE;
    endcase
  end

  // item execution
  logic [4:0] push_cnt;
  logic [3:0] per_eff;
  always_comb begin
    phase_d = phase_q; cmd_d = cmd_q; args_taken_d = args_taken_q;
    args_needed_d = args_needed_q; drive_d = drive_q; head_d = head_q;
    track_d = track_q; sector_d = sector_q; off_d = off_q; cnt_d = cnt_q;
    per_d = per_q; ticks_d = ticks_q; seek_d = seek_q; head_ptr_d = head_ptr_q;
    fcount_d = fcount_q; status_d = status_q; irq_d = irq_q;
    zero_pend_d = 1'b0; zero_addr_d = zero_addr_q;
    out_d = '0;
    disk_we = 1'b0; disk_waddr = item_q.image_addr; disk_wdata = item_q.value;
    fifo_we = 1'b0; fifo_waddr = head_ptr_q + fcount_q[3:0]; fifo_wdata = item_q.value;
    start_xfer = 1'b0;
    push_cnt = fcount_q;
    lin = 12'(mul1_q * spt_q) + 12'(sector_q) - 12'd1;
    per_eff = (cmd_q == fdc_pkg::CmdRd) ? rd_per_q : wr_per_q;
    if (per_eff == 4'd0) per_eff = 4'd1;
    if (fsm_q == fdc_pkg::ST_MUL2) begin
      // lin*512 mod image size: keep the low bits
      off_d   = {lin[OffW-10:0], 9'd0};
      per_d   = per_eff;
      cnt_d   = per_eff;
      ticks_d = {per_eff, 9'd0};
      phase_d = fdc_pkg::PH_EXEC;
    end else if (fsm_q == fdc_pkg::ST_EXEC) begin
      unique case (item_q.op)
        fdc_pkg::OP_BUS_READ: begin
          if (!item_q.port) begin
            out_d.read_data = status_q;
          end else begin
            out_d.read_data = fifo_rd_q;
            if (fcount_q != 5'd0) begin
              head_ptr_d = head_ptr_q + 4'd1;
              fcount_d = fcount_q - 5'd1;
            end
            if (fcount_d == 5'd0) begin
              status_d = status_d & ~fdc_pkg::StDrq;
              if (phase_q == fdc_pkg::PH_RESULT) phase_d = fdc_pkg::PH_CMD;
            end
          end
        end
        fdc_pkg::OP_BUS_WRITE: begin
          if (item_q.port) begin
            unique case (phase_q)
              fdc_pkg::PH_CMD: begin
                cmd_d = item_q.value;
                head_ptr_d = '0; fcount_d = '0; args_taken_d = '0;
                if (item_q.value == fdc_pkg::CmdRd || item_q.value == fdc_pkg::CmdWr) begin
                  args_needed_d = 3'd4; phase_d = fdc_pkg::PH_ARGS;
                  status_d = status_q | fdc_pkg::StBusy;
                end else if (item_q.value == fdc_pkg::CmdSk) begin
                  args_needed_d = 3'd2; phase_d = fdc_pkg::PH_ARGS;
                  status_d = status_q | fdc_pkg::StBusy;
                end else begin
                  args_needed_d = 3'd0;
                  status_d = status_q & ~fdc_pkg::StBusy;
                end
              end
              fdc_pkg::PH_ARGS: begin
                args_taken_d = args_taken_q + 3'd1;
                if (cmd_q == fdc_pkg::CmdRd || cmd_q == fdc_pkg::CmdWr) begin
                  unique case (args_taken_q)
                    3'd0: drive_d = item_q.value[1:0];
                    3'd1: head_d = item_q.value;
                    3'd2: begin
                      if (track_q != item_q.value) seek_d = seek_dly_q;
                      track_d = item_q.value;
                    end
                    default: begin
                      sector_d = item_q.value;
                      start_xfer = 1'b1;
                    end
                  endcase
                end else if (args_taken_d >= args_needed_q) begin
                  status_d = status_q & ~fdc_pkg::StBusy;
                  phase_d = fdc_pkg::PH_CMD;
                end
              end
              fdc_pkg::PH_EXEC: begin
                if (fcount_q < 5'(fdc_pkg::FifoDepth)) begin
                  fifo_we = 1'b1;
                  fcount_d = fcount_q + 5'd1;
                  if (fcount_d >= 5'(fdc_pkg::FifoDepth))
                    status_d = status_q & ~fdc_pkg::StDrq;
                end
              end
              default: ;
            endcase
          end
        end
        fdc_pkg::OP_TICK: begin
          if (seek_q != 8'd0) begin
            seek_d = seek_q - 8'd1;
            if (seek_d == 8'd0) status_d = status_q & ~fdc_pkg::StBusy;
          end else if (phase_q == fdc_pkg::PH_EXEC && ticks_q != 13'd0) begin
            ticks_d = ticks_q - 13'd1;
            if (cnt_q <= 4'd1) begin
              cnt_d = per_q;
              if (fcount_q < 5'(fdc_pkg::FifoDepth)) begin
                if (cmd_q == fdc_pkg::CmdRd) begin
                  fifo_we = 1'b1;
                  fifo_wdata = disk_rd_q;
                  push_cnt = fcount_q + 5'd1;
                  off_d = off_q + OffW'(1);
                  status_d = status_d | fdc_pkg::StDrq;
                end else if (cmd_q == fdc_pkg::CmdWr && fcount_q != 5'd0) begin
                  disk_we = 1'b1;
                  disk_waddr = {drive_q[DrvW-1:0], off_q};
                  disk_wdata = fifo_rd_q;
                  off_d = off_q + OffW'(1);
                  head_ptr_d = head_ptr_q + 4'd1;
                  push_cnt = fcount_q - 5'd1;
                  status_d = status_d | fdc_pkg::StDrq;
                end
              end
            end else begin
              cnt_d = cnt_q - 4'd1;
            end
            fcount_d = push_cnt;
            if (ticks_d == 13'd0) begin
              status_d = (status_d & ~fdc_pkg::StBusy) | fdc_pkg::StDrq;
              irq_d = 1'b1;
              phase_d = fdc_pkg::PH_RESULT;
              // queue the zero result byte behind the data; a read push may
              // own the FIFO write port now, so write it while the result waits
              if (push_cnt < 5'(fdc_pkg::FifoDepth)) begin
                zero_pend_d = 1'b1;
                zero_addr_d = head_ptr_d + push_cnt[3:0];
                fcount_d = push_cnt + 5'd1;
              end
            end
          end
        end
        fdc_pkg::OP_LOAD: begin
          if ({1'b0, item_q.image_addr} < fdc_pkg::StoreLimit) disk_we = 1'b1;
        end
        fdc_pkg::OP_DUMP: begin
          if ({1'b0, item_q.image_addr} < fdc_pkg::StoreLimit)
            out_d.read_data = disk_rd_q;
        end
        default: ;
      endcase
      out_d.irq = irq_d;
    end else if (fsm_q == fdc_pkg::ST_OUT && zero_pend_q) begin
      fifo_we = 1'b1;
      fifo_waddr = zero_addr_q;
      fifo_wdata = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= fdc_pkg::ST_IDLE; phase_q <= fdc_pkg::PH_CMD; cmd_q <= '0;
      args_taken_q <= '0; args_needed_q <= '0; drive_q <= '0; head_q <= '0;
      track_q <= '0; sector_q <= '0; off_q <= '0; cnt_q <= '0; per_q <= '0;
      ticks_q <= '0; seek_q <= '0; head_ptr_q <= '0; fcount_q <= '0;
      status_q <= '0; irq_q <= 1'b0; zero_pend_q <= 1'b0; zero_addr_q <= '0;
    end else begin
      fsm_q <= fsm_d; phase_q <= phase_d; cmd_q <= cmd_d;
      args_taken_q <= args_taken_d; args_needed_q <= args_needed_d;
      drive_q <= drive_d; head_q <= head_d; track_q <= track_d;
      sector_q <= sector_d; off_q <= off_d; cnt_q <= cnt_d; per_q <= per_d;
      ticks_q <= ticks_d; seek_q <= seek_d; head_ptr_q <= head_ptr_d;
      fcount_q <= fcount_d; status_q <= status_d; irq_q <= irq_d;
      zero_pend_q <= zero_pend_d; zero_addr_q <= zero_addr_d;
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= 5'(fdc_pkg::FifoDepth)) else $error("fifo count overflow");
  a_irq_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q |=> irq_q) else $error("irq cleared");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o) else $error("item taken while busy");
endmodule

[dv/tb.sv]
// Testbench: directed table and random command sequences checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import fdc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 350;
  localparam logic [2:0]  OpReserved = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic        port;
    logic [7:0]  value;
    logic [22:0] addr;
    bit          typed;
    logic [7:0]  rd;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_t      cfg_data = '0;

  floppy_disk_controller i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Controller state as the predictor sees it
  logic [1:0]  geo_heads = 2'd2;
  logic [5:0]  geo_sectors = 6'd18;
  logic [3:0]  rd_period = 4'd11;
  logic [3:0]  wr_period = 4'd4;
  logic [7:0]  seek_len = 8'd100;

  phase_e      ctl_phase = PH_CMD;
  logic [7:0]  cmd_code = '0;
  int unsigned args_got = 0, args_want = 0;
  logic [1:0]  drive_sel = '0;
  logic [7:0]  head_sel = '0, track_sel = '0, sector_sel = '0;
  logic [20:0] sector_off = '0;
  int unsigned byte_cnt = 0, byte_per = 0, ticks_rem = 0, seek_rem = 0;
  logic [7:0]  fifo_mem [FifoDepth];
  bit          fifo_valid [FifoDepth];
  logic [3:0]  fifo_rd = '0;
  int unsigned fifo_fill = 0;
  logic [7:0]  status_reg = '0;
  bit          irq_reg = 1'b0;
  logic [7:0]  disk_img [int unsigned];
  int unsigned loaded_addrs [$];

  out_item_t   expected_results [$];
  int unsigned errors = 0;
  int unsigned in_taken = 0, cfg_taken = 0, cycles = 0, rx_cycles = 0, hold_left = 0;
  int unsigned items_sent = 0;

  function automatic int unsigned disk_addr();
    return 32'({drive_sel, sector_off});
  endfunction

  function automatic void fifo_push(logic [7:0] v);
    int unsigned idx;
    if (fifo_fill >= FifoDepth) return;
    idx = (fifo_rd + fifo_fill) % FifoDepth;
    fifo_mem[idx] = v;
    fifo_valid[idx] = 1'b1;
    fifo_fill++;
  endfunction

  function automatic void end_noop();
    status_reg &= ~StBusy;
    ctl_phase = PH_CMD;
  endfunction

  function automatic void begin_sector();
    logic [31:0] lin;
    logic [3:0]  per;
    lin = (32'(track_sel) * 32'(geo_heads) + 32'(head_sel)) * 32'(geo_sectors)
          + 32'(sector_sel) - 32'd1;
    per = (cmd_code == CmdRd) ? rd_period : wr_period;
    if (per == 0) per = 4'd1;
    sector_off = {lin[11:0], 9'b0};
    byte_per = per;
    byte_cnt = per;
    ticks_rem = per * SectorBytes;
    ctl_phase = PH_EXEC;
  endfunction

  function automatic void bus_write(logic port, logic [7:0] v);
    if (port != 1'b1) return;
    case (ctl_phase)
      PH_CMD: begin
        cmd_code = v;
        status_reg |= StBusy;
        fifo_rd = '0;
        fifo_fill = 0;
        args_got = 0;
        ctl_phase = PH_ARGS;
        args_want = (v == CmdRd || v == CmdWr) ? 4 : (v == CmdSk) ? 2 : 0;
        if (args_want == 0) end_noop();
      end
      PH_ARGS: begin
        if (cmd_code == CmdRd || cmd_code == CmdWr) begin
          case (args_got)
            0: drive_sel = v[1:0];
            1: head_sel = v;
            2: begin
              if (track_sel != v) seek_rem = seek_len;
              track_sel = v;
            end
            default: begin
              sector_sel = v;
              begin_sector();
            end
          endcase
          args_got++;
        end else begin
          args_got++;
          if (args_got >= args_want) end_noop();
        end
      end
      PH_EXEC: begin
        if (fifo_fill >= FifoDepth) return;
        fifo_push(v);
        if (fifo_fill >= FifoDepth) status_reg &= ~StDrq;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] bus_read(logic port);
    logic [7:0] v;
    if (port == 1'b0) return status_reg;
    v = fifo_mem[fifo_rd];
    if (fifo_fill > 0) begin
      fifo_rd++;
      fifo_fill--;
    end
    if (fifo_fill == 0) begin
      status_reg &= ~StDrq;
      if (ctl_phase == PH_RESULT) ctl_phase = PH_CMD;
    end
    return v;
  endfunction

  function automatic void tick();
    if (seek_rem > 0) begin
      seek_rem--;
      if (seek_rem == 0) status_reg &= ~StBusy;
      return;
    end
    if (ctl_phase != PH_EXEC || ticks_rem == 0) return;
    ticks_rem--;
    if (byte_cnt <= 1) begin
      byte_cnt = byte_per;
      if (fifo_fill < FifoDepth) begin
        if (cmd_code == CmdRd) begin
          fifo_push(disk_img[disk_addr()]);
          sector_off++;
          status_reg |= StDrq;
        end else if (cmd_code == CmdWr && fifo_fill > 0) begin
          if (!disk_img.exists(disk_addr())) loaded_addrs.push_back(disk_addr());
          disk_img[disk_addr()] = fifo_mem[fifo_rd];
          sector_off++;
          fifo_rd++;
          fifo_fill--;
          status_reg |= StDrq;
        end
      end
    end else begin
      byte_cnt--;
    end
    if (ticks_rem == 0) begin
      status_reg &= ~StBusy;
      irq_reg = 1'b1;
      fifo_push(8'h00);
      ctl_phase = PH_RESULT;
      status_reg |= StDrq;
    end
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.op)
      OP_BUS_READ:  r.read_data = bus_read(it.port);
      OP_BUS_WRITE: bus_write(it.port, it.value);
      OP_TICK:      tick();
      OP_LOAD: begin
        if (!disk_img.exists(it.image_addr)) loaded_addrs.push_back(it.image_addr);
        disk_img[it.image_addr] = it.value;
      end
      OP_DUMP:      r.read_data = disk_img[it.image_addr];
      default: ;
    endcase
    r.irq = irq_reg;
    return r;
  endfunction

  // Replace an item that would read a never-written store or FIFO entry.
  function automatic in_item_t make_safe(in_item_t it);
    if (it.op == OP_TICK && seek_rem == 0 && ctl_phase == PH_EXEC && ticks_rem > 0
        && byte_cnt <= 1 && fifo_fill < FifoDepth && cmd_code == CmdRd
        && !disk_img.exists(disk_addr())) begin
      it.op = OP_LOAD;
      it.image_addr = 23'(disk_addr());
    end else if (it.op == OP_BUS_READ && it.port && !fifo_valid[fifo_rd]) begin
      it.port = 1'b0;
    end else if (it.op == OP_DUMP) begin
      if (loaded_addrs.size() == 0) begin
        it.op = OP_BUS_READ;
        it.port = 1'b0;
      end else begin
        it.image_addr = 23'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
      end
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, logic [7:0] typed_rd);
    out_item_t r;
    int unsigned target;
    r = predict_item(it);
    if (typed) r.read_data = typed_rd;
    expected_results.push_back(r);
    if (!(items_sent >= 300 && items_sent < 700) && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    target = in_taken + 1;
    do @(negedge clk); while (in_taken < target);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] d);
    int unsigned target;
    case (idx)
      CFG_HEADS:   geo_heads = d[1:0];
      CFG_SECTORS: geo_sectors = d[5:0];
      CFG_RD_PER:  rd_period = d[3:0];
      CFG_WR_PER:  wr_period = d[3:0];
      CFG_SEEK:    seek_len = d;
      default: ;
    endcase
    cfg_data <= '{index: idx, data: d};
    cfg_valid <= 1'b1;
    target = cfg_taken + 1;
    do @(negedge clk); while (cfg_taken < target);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    it.op = OP_TICK;
    it.port = 1'($urandom_range(0, 1));
    it.value = 8'($urandom);
    it.image_addr = 23'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.op = 3'($urandom_range(0, 7));
      return make_safe(it);
    end
    case (ctl_phase)
      PH_CMD: begin
        it.op = OP_BUS_WRITE;
        it.port = 1'b1;
        pick = $urandom_range(0, 99);
        it.value = (pick < 50) ? CmdWr : (pick < 80) ? CmdRd : (pick < 90) ? CmdSk
                 : 8'($urandom);
      end
      PH_ARGS: begin
        it.op = OP_BUS_WRITE;
        it.port = 1'b1;
        pick = $urandom_range(0, 9);
        case (args_got)
          1: if (pick < 8) it.value = 8'($urandom_range(0, 2));
          2: if (pick < 8) it.value = 8'($urandom_range(0, 3));
          3: if (pick < 8) it.value = 8'($urandom_range(0, geo_sectors + 1));
          default: ;
        endcase
      end
      PH_EXEC: begin
        if (pick < 60) it.op = OP_TICK;
        else if (pick < 75) begin
          it.op = OP_BUS_WRITE;
          it.port = 1'b1;
        end else if (pick < 92) begin
          it.op = OP_BUS_READ;
          it.port = 1'b1;
        end else it.op = OP_BUS_READ;
      end
      default: begin
        it.op = (pick < 60) ? OP_BUS_READ : OP_TICK;
        it.port = (pick < 55);
      end
    endcase
    return make_safe(it);
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_item(random_item(), 1'b0, 8'h00);
  endtask

  row_t dir_rows [25] = '{
    '{OP_BUS_READ,  1'b0, 8'h00, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_WRITE, 1'b0, 8'hFF, 23'h0,      1'b1, 8'h00},
    '{OpReserved,   1'b1, 8'hFF, 23'h7FFFFF, 1'b1, 8'h00},
    '{OP_LOAD,      1'b0, 8'h5A, 23'h0,      1'b1, 8'h00},
    '{OP_DUMP,      1'b0, 8'h00, 23'h0,      1'b1, 8'h5A},
    '{OP_LOAD,      1'b1, 8'hFF, 23'h7FFFFF, 1'b1, 8'h00},
    '{OP_DUMP,      1'b1, 8'h00, 23'h7FFFFF, 1'b1, 8'hFF},
    '{OP_BUS_WRITE, 1'b1, 8'h03, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_READ,  1'b0, 8'h00, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_WRITE, 1'b1, CmdSk, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h12, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h34, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_READ,  1'b0, 8'h00, 23'h0,      1'b1, 8'h00},
    '{OP_BUS_WRITE, 1'b1, CmdWr, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'hFF, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_READ,  1'b0, 8'h00, 23'h0,      1'b1, StBusy},
    '{OP_BUS_WRITE, 1'b1, 8'hA5, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_WRITE, 1'b1, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_READ,  1'b1, 8'h00, 23'h0,      1'b1, 8'hA5},
    '{OP_TICK,      1'b0, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_TICK,      1'b0, 8'h00, 23'h0,      1'b0, 8'h00},
    '{OP_BUS_READ,  1'b0, 8'h00, 23'h0,      1'b0, 8'h00}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** floppy_disk_controller: FAILED **");
      $finish;
    end
    if (in_valid && in_ready) in_taken <= in_taken + 1;
    if (cfg_valid && cfg_ready) cfg_taken <= cfg_taken + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        if (out_data.read_data !== expected_results[0].read_data) begin
          $display("%0t: read_data expected %02h actual %02h", $time,
                   expected_results[0].read_data, out_data.read_data);
          errors++;
        end
        if (out_data.irq !== expected_results[0].irq) begin
          $display("%0t: irq expected %0b actual %0b", $time,
                   expected_results[0].irq, out_data.irq);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Receiver: random stalls, one long hold-off, then a stretch always ready.
  always @(negedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles == 1500) hold_left <= 400;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_cycles >= 4000 && rx_cycles < 7000) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    in_item_t it;
    for (int i = 0; i < FifoDepth; i++) begin
      fifo_mem[i] = '0;
      fifo_valid[i] = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      it.op = dir_rows[i].op;
      it.port = dir_rows[i].port;
      it.value = dir_rows[i].value;
      it.image_addr = dir_rows[i].addr;
      send_item(it, dir_rows[i].typed, dir_rows[i].rd);
    end
    run_random(PhaseItems - 25);
    in_valid <= 1'b0;
    drain();

    // Smallest nonzero geometry and timing settings
    write_reg(CFG_HEADS, 8'd1);
    write_reg(CFG_SECTORS, 8'd1);
    write_reg(CFG_RD_PER, 8'd1);
    write_reg(CFG_WR_PER, 8'd1);
    write_reg(CFG_SEEK, 8'd1);
    run_random(PhaseItems);
    in_valid <= 1'b0;
    drain();

    write_reg(CFG_HEADS, 8'd2);
    write_reg(CFG_SECTORS, 8'd36);
    write_reg(CFG_RD_PER, 8'd2);
    write_reg(CFG_SEEK, 8'd255);
    run_random(PhaseItems);
    in_valid <= 1'b0;
    drain();

    write_reg(CFG_SECTORS, 8'd5);
    write_reg(CFG_RD_PER, 8'd15);
    write_reg(CFG_WR_PER, 8'd15);
    write_reg(CFG_SEEK, 8'd3);
    run_random(PhaseItems);
    in_valid <= 1'b0;
    drain();

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("** floppy_disk_controller: PASSED **");
    end else begin
      $display("** floppy_disk_controller: FAILED **");
    end
    $finish;
  end
endmodule

[sim.f]
design/fdc_pkg.sv
design/floppy_disk_controller.sv
dv/tb.sv
